// File: rtl/fpd_pkg.sv
// package: shared constants, config and header types for the framed packet deframer
`timescale 1ns / 1ps
package fpd_pkg;

  localparam int unsigned HEADER_BYTES = 18;
  localparam int unsigned LENGTH_BITS_DEF = 24;
  localparam int unsigned FILL_W = $clog2(HEADER_BYTES + 1);
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [31:0] MAGIC_RST = 32'h4152_4C56;
  localparam logic [7:0]  VERSION_RST = 8'd1;
  localparam logic [7:0]  MAX_TYPE_RST = 8'd15;
  localparam logic [23:0] MAX_LEN_RST = 24'd1048576;

  // header byte offsets
  localparam int unsigned OFS_VERSION = 4;
  localparam int unsigned OFS_TYPE = 5;
  localparam int unsigned OFS_LENGTH = 6;
  localparam int unsigned OFS_STAMP = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAGIC    = 2'd0,
    REG_VERSION  = 2'd1,
    REG_MAX_TYPE = 2'd2,
    REG_MAX_LEN  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] magic;
    logic [7:0]  version;
    logic [7:0]  max_type;
    logic [23:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic        full;
    logic        ok;
    logic        known;
    logic [7:0]  ptype;
    logic [31:0] len;
    logic [63:0] stamp;
  } hdr_t;

endpackage

// File: rtl/fpd_cfg_regs.sv
// configuration registers written through the plain write port
`timescale 1ns / 1ps
module fpd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fpd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output fpd_pkg::cfg_t                cfg_o
);
  import fpd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MAGIC:    cfg_d.magic = cfg_wdata_i[31:0];
        REG_VERSION:  cfg_d.version = cfg_wdata_i[7:0];
        REG_MAX_TYPE: cfg_d.max_type = cfg_wdata_i[7:0];
        REG_MAX_LEN:  cfg_d.max_len = cfg_wdata_i[23:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic <= MAGIC_RST;
      cfg_q.version <= VERSION_RST;
      cfg_q.max_type <= MAX_TYPE_RST;
      cfg_q.max_len <= MAX_LEN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/fpd_hdr_window.sv
// header window shift line, fill count and header check
`timescale 1ns / 1ps
module fpd_hdr_window #(
  parameter int unsigned LENGTH_BITS = fpd_pkg::LENGTH_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [7:0]    byte_i,
  input  logic          clr_i,
  input  fpd_pkg::cfg_t cfg_i,
  output fpd_pkg::hdr_t hdr_o
);
  import fpd_pkg::*;

  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(HEADER_BYTES - 1);

  logic [7:0]        win_q [HEADER_BYTES];
  logic [7:0]        win_n [HEADER_BYTES];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [31:0]       magic;
  logic [31:0]       len;
  logic [63:0]       stamp;
  hdr_t              hdr;

  // window as it stands once the incoming byte is shifted in
  always_comb begin
    for (int i = 0; i < HEADER_BYTES - 1; i++) begin
      win_n[i] = win_q[i + 1];
    end
    win_n[HEADER_BYTES - 1] = byte_i;
  end

  always_comb begin
    magic = {win_n[0], win_n[1], win_n[2], win_n[3]};
    len = {win_n[OFS_LENGTH], win_n[OFS_LENGTH + 1], win_n[OFS_LENGTH + 2],
           win_n[OFS_LENGTH + 3]};
    stamp = {win_n[OFS_STAMP], win_n[OFS_STAMP + 1], win_n[OFS_STAMP + 2],
             win_n[OFS_STAMP + 3], win_n[OFS_STAMP + 4], win_n[OFS_STAMP + 5],
             win_n[OFS_STAMP + 6], win_n[OFS_STAMP + 7]};
    hdr.full = (fill_q == FILL_LAST);
    hdr.ok = (magic == cfg_i.magic) && (win_n[OFS_VERSION] == cfg_i.version) &&
             (len <= {8'd0, cfg_i.max_len}) && ((len >> LENGTH_BITS) == 32'd0);
    hdr.known = (win_n[OFS_TYPE] <= cfg_i.max_type);
    hdr.ptype = win_n[OFS_TYPE];
    hdr.len = len;
    hdr.stamp = stamp;
  end

  always_comb begin
    fill_d = fill_q;
    if (push_i) begin
      if (hdr.full) begin
        fill_d = hdr.ok ? '0 : FILL_LAST;
      end else begin
        fill_d = fill_q + FILL_W'(1);
      end
    end else if (clr_i) begin
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      win_q <= win_n;
    end
  end

  assign hdr_o = hdr;

endmodule

// File: rtl/framed_packet_deframer.sv
// Byte-serial deframer for magic-word framed packets. One byte is accepted per clock
// cycle while the output side does not stall; a byte enters an input register and its
// result, if any, is loaded into the output register when the output side advances,
// and the sustained rate is one item per cycle while the output side does not stall.
// A stalled result holds the output register, and the input register then stalls the
// input. Each byte outside a payload is shifted into an 18-byte header window; once the
// window is full it is compared combinationally against the magic word, version and
// length limit. A failing window drops its oldest byte, a good header with an unknown
// type skips its payload silently, and a good known header streams its payload bytes
// out tagged with type, timestamp and length, the final byte marked last. A zero-length
// packet gives one result without a byte.
`timescale 1ns / 1ps
module framed_packet_deframer #(
  parameter int unsigned LENGTH_BITS = fpd_pkg::LENGTH_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fpd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     packet_type_o,
  output logic signed [63:0]             header_stamp_o,
  output logic [23:0]                    payload_length_o,
  output logic                           has_byte_o,
  output logic [7:0]                     payload_byte_o,
  output logic                           last_o
);
  import fpd_pkg::*;

  cfg_t cfg;
  hdr_t hdr;

  logic                   in_vld_q;
  logic [7:0]             byte_q;
  logic                   adv, proc, in_acc;
  logic                   in_pay_q, in_pay_d;
  logic                   skip_q, skip_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [7:0]             held_type_q, held_type_d;
  logic [63:0]            held_ts_q, held_ts_d;
  logic [23:0]            held_len_q, held_len_d;
  logic                   push, clr, pay_end;

  logic        res_vld;
  logic [7:0]  res_type;
  logic [63:0] res_ts;
  logic [23:0] res_len;
  logic        res_has;
  logic [7:0]  res_byte;
  logic        res_last;

  logic        out_vld_q;
  logic [7:0]  o_type_q;
  logic [63:0] o_ts_q;
  logic [23:0] o_len_q;
  logic        o_has_q;
  logic [7:0]  o_byte_q;
  logic        o_last_q;

  fpd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  fpd_hdr_window #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_win (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .byte_i (byte_q),
    .clr_i  (clr),
    .cfg_i  (cfg),
    .hdr_o  (hdr)
  );

  assign adv = !out_vld_q || !out_stall_i;
  assign proc = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign in_acc = in_valid_i && !in_stall_o;

  assign pay_end = (rem_q <= LENGTH_BITS'(1));
  assign push = proc && !in_pay_q && !skip_q;
  assign clr = proc && (in_pay_q || skip_q) && pay_end;

  always_comb begin
    in_pay_d = in_pay_q;
    skip_d = skip_q;
    rem_d = rem_q;
    held_type_d = held_type_q;
    held_ts_d = held_ts_q;
    held_len_d = held_len_q;
    res_vld = 1'b0;
    res_type = held_type_q;
    res_ts = held_ts_q;
    res_len = held_len_q;
    res_has = 1'b1;
    res_byte = byte_q;
    res_last = 1'b0;
    if (proc) begin
      if (in_pay_q || skip_q) begin
        rem_d = (rem_q != '0) ? rem_q - LENGTH_BITS'(1) : rem_q;
        if (pay_end) begin
          in_pay_d = 1'b0;
          skip_d = 1'b0;
        end
        res_vld = in_pay_q;
        res_last = pay_end;
      end else if (hdr.full && hdr.ok) begin
        if (!hdr.known) begin
          if (hdr.len != 32'd0) begin
            skip_d = 1'b1;
            rem_d = hdr.len[LENGTH_BITS-1:0];
          end
        end else begin
          held_type_d = hdr.ptype;
          held_ts_d = hdr.stamp;
          held_len_d = hdr.len[23:0];
          res_type = hdr.ptype;
          res_ts = hdr.stamp;
          res_len = hdr.len[23:0];
          if (hdr.len == 32'd0) begin
            res_vld = 1'b1;
            res_has = 1'b0;
            res_byte = 8'd0;
            res_last = 1'b1;
          end else begin
            in_pay_d = 1'b1;
            rem_d = hdr.len[LENGTH_BITS-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      in_pay_q <= 1'b0;
      skip_q <= 1'b0;
      rem_q <= '0;
      held_type_q <= '0;
      held_ts_q <= '0;
      held_len_q <= '0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (proc) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= res_vld;
      end
      in_pay_q <= in_pay_d;
      skip_q <= skip_d;
      rem_q <= rem_d;
      held_type_q <= held_type_d;
      held_ts_q <= held_ts_d;
      held_len_q <= held_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= data_byte_i;
    end
    if (res_vld) begin
      o_type_q <= res_type;
      o_ts_q <= res_ts;
      o_len_q <= res_len;
      o_has_q <= res_has;
      o_byte_q <= res_byte;
      o_last_q <= res_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign packet_type_o = o_type_q;
  assign header_stamp_o = o_ts_q;
  assign payload_length_o = o_len_q;
  assign has_byte_o = o_has_q;
  assign payload_byte_o = o_byte_q;
  assign last_o = o_last_q;

endmodule
